@@ rtl/core/dfbq_pkg.sv @@
// Shared types and constants for the distance field bilinear query core.
package dfbq_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XB         = $clog2(MAX_WIDTH);
  localparam int YB         = $clog2(MAX_HEIGHT);
  localparam int BANK_AW    = (XB - 1) + (YB - 1);
  localparam int DIM_W      = 9;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_UNUSABLE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH     = 3'd0,
    REG_GRID_HEIGHT    = 3'd1,
    REG_CORNER_X       = 3'd2,
    REG_CORNER_Y       = 3'd3,
    REG_INV_RESOLUTION = 3'd4,
    REG_MIN_DISTANCE   = 3'd5,
    REG_MAX_DISTANCE   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] grid_width;
    logic [DIM_W-1:0] grid_height;
    logic [31:0]      corner_x;
    logic [31:0]      corner_y;
    logic [31:0]      inv_resolution;
    logic [31:0]      min_distance;
    logic [31:0]      max_distance;
  } cfg_t;

  // Side information of one item at the grid read stage.
  typedef struct packed {
    logic        is_query;
    status_t     status;
    logic [15:0] fx;
    logic [15:0] fy;
    logic        ix0;
    logic        iy0;
  } loc_info_t;

endpackage

@@ rtl/core/dfbq_locate.sv @@
// Position to cell conversion: offset, scale by inverse resolution, half-cell shift.
module dfbq_locate import dfbq_pkg::*; (
  input  logic          clk,
  input  logic          advance,
  input  cfg_t          cfg,
  input  logic          in_query,
  input  logic [XB-1:0] cell_x,
  input  logic [YB-1:0] cell_y,
  input  logic [31:0]   cell_distance,
  input  logic [31:0]   pos_x,
  input  logic [31:0]   pos_y,
  output loc_info_t     info,
  output logic [XB-1:0] ix,
  output logic [YB-1:0] iy,
  output logic [XB-1:0] wr_x,
  output logic [YB-1:0] wr_y,
  output logic [31:0]   wr_data
);

  logic          q1, q2;
  logic [32:0]   dx1, dy1;
  logic [XB-1:0] cx1, cx2;
  logic [YB-1:0] cy1, cy2;
  logic [31:0]   cd1, cd2;
  logic          negx2, negy2;
  logic [63:0]   px2, py2;
  logic [32:0]   dx, dy;
  logic [63:0]   qx, qy;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic          unusable, outside;

  assign dx = {pos_x[31], pos_x} - {cfg.corner_x[31], cfg.corner_x};
  assign dy = {pos_y[31], pos_y} - {cfg.corner_y[31], cfg.corner_y};

  always_ff @(posedge clk) begin
    if (advance) begin
      q1    <= in_query;
      dx1   <= dx;
      dy1   <= dy;
      cx1   <= cell_x;
      cy1   <= cell_y;
      cd1   <= cell_distance;
      q2    <= q1;
      negx2 <= dx1[32];
      negy2 <= dy1[32];
      px2   <= dx1[31:0] * cfg.inv_resolution;
      py2   <= dy1[31:0] * cfg.inv_resolution;
      cx2   <= cx1;
      cy2   <= cy1;
      cd2   <= cd1;
    end
  end

  assign w_eff = (cfg.grid_width  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : cfg.grid_width;
  assign h_eff = (cfg.grid_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg.grid_height;
  assign unusable = (w_eff < DIM_W'(2)) || (h_eff < DIM_W'(2)) || (cfg.inv_resolution == 32'd0);

  // The half-cell shift is 0.5 in the Q32.32 cell coordinate.
  assign qx = px2 - 64'h0000_0000_8000_0000;
  assign qy = py2 - 64'h0000_0000_8000_0000;
  assign outside = negx2 || negy2
                || (px2 < 64'h0000_0000_8000_0000) || (py2 < 64'h0000_0000_8000_0000)
                || (qx[63:32] >= {23'd0, w_eff - DIM_W'(1)})
                || (qy[63:32] >= {23'd0, h_eff - DIM_W'(1)});

  always_comb begin
    info.is_query = q2;
    info.status   = unusable ? ST_UNUSABLE : (outside ? ST_OUTSIDE : ST_OK);
    info.fx       = qx[31:16];
    info.fy       = qy[31:16];
    info.ix0      = qx[32];
    info.iy0      = qy[32];
  end

  assign ix      = qx[32+XB-1:32];
  assign iy      = qy[32+YB-1:32];
  assign wr_x    = cx2;
  assign wr_y    = cy2;
  assign wr_data = cd2;

endmodule

@@ rtl/core/dfbq_grid_mem.sv @@
// Distance grid in four banks by cell parity, giving all four neighbors per cycle while the pipeline advances.
module dfbq_grid_mem import dfbq_pkg::*; (
  input  logic             clk,
  input  logic             advance,
  input  logic             wr_en,
  input  logic [XB-1:0]    wr_x,
  input  logic [YB-1:0]    wr_y,
  input  logic [31:0]      wr_data,
  input  logic [XB-1:0]    ix,
  input  logic [YB-1:0]    iy,
  output logic [3:0][31:0] rd_data
);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'(b % 2);
    localparam logic BY = 1'(b / 2);
    logic [31:0]   mem [2**BANK_AW];
    logic [XB-2:0] rcol;
    logic [YB-2:0] rrow;
    logic [31:0]   rdata;

    // A bank of the other parity than the base cell holds the next column or row.
    assign rcol = ix[XB-1:1] + (XB-1)'(ix[0] & ~BX);
    assign rrow = iy[YB-1:1] + (YB-1)'(iy[0] & ~BY);

    always_ff @(posedge clk) begin
      if (advance) begin
        if (wr_en && (wr_x[0] == BX) && (wr_y[0] == BY)) begin
          mem[{wr_y[YB-1:1], wr_x[XB-1:1]}] <= wr_data;
        end
        rdata <= mem[{rrow, rcol}];
      end
    end

    assign rd_data[b] = rdata;
  end

endmodule

@@ rtl/core/dfbq_interp.sv @@
// Bilinear blend, gradient scaling and clamping over five pipeline stages.
module dfbq_interp import dfbq_pkg::*; (
  input  logic             clk,
  input  logic             advance,
  input  cfg_t             cfg,
  input  loc_info_t        info,
  input  logic [3:0][31:0] rd_data,
  output status_t          status,
  output logic             clamped,
  output logic [31:0]      distance,
  output logic [31:0]      grad_x,
  output logic [31:0]      grad_y
);

  // Stage 4: neighbor selection and first products.
  logic signed [31:0] d00, d10, d01, d11;
  logic signed [17:0] wfx0, wfx1, wfy0, wfy1;
  logic signed [32:0] ex0, ex1, ey0, ey1;
  logic signed [49:0] p00, p10, p01, p11;
  logic signed [50:0] gx0, gx1, gy0, gy1;
  logic [16:0]        fy0_4, fy1_4;
  loc_info_t          i4, i5, i6, i7;

  assign d00  = rd_data[{info.iy0, info.ix0}];
  assign d10  = rd_data[{info.iy0, ~info.ix0}];
  assign d01  = rd_data[{~info.iy0, info.ix0}];
  assign d11  = rd_data[{~info.iy0, ~info.ix0}];
  assign wfx1 = {2'b00, info.fx};
  assign wfx0 = 18'sd65536 - wfx1;
  assign wfy1 = {2'b00, info.fy};
  assign wfy0 = 18'sd65536 - wfy1;
  assign ex0  = d10 - d00;
  assign ex1  = d11 - d01;
  assign ey0  = d01 - d00;
  assign ey1  = d11 - d10;

  always_ff @(posedge clk) begin
    if (advance) begin
      p00   <= d00 * wfx0;
      p10   <= d10 * wfx1;
      p01   <= d01 * wfx0;
      p11   <= d11 * wfx1;
      gx0   <= ex0 * wfy0;
      gx1   <= ex1 * wfy1;
      gy0   <= ey0 * wfx0;
      gy1   <= ey1 * wfx1;
      fy0_4 <= wfy0[16:0];
      fy1_4 <= wfy1[16:0];
      i4    <= info;
    end
  end

  // Stage 5: row blends and gradient sums.
  logic signed [50:0] y0, y1;
  logic signed [51:0] wx, wy;
  logic [16:0]        fy0_5, fy1_5;

  always_ff @(posedge clk) begin
    if (advance) begin
      y0    <= 51'(p00) + 51'(p10);
      y1    <= 51'(p01) + 51'(p11);
      wx    <= 52'(gx0) + 52'(gx1);
      wy    <= 52'(gy0) + 52'(gy1);
      fy0_5 <= fy0_4;
      fy1_5 <= fy1_4;
      i5    <= i4;
    end
  end

  // Stage 6: column blend products and gradient times inverse resolution.
  logic signed [68:0] r0, r1;
  logic [50:0]        mx, my;
  logic [66:0]        ahx, alx, ahy, aly;
  logic               negx6, negy6;

  assign mx = wx[51] ? 51'(-wx) : 51'(wx);
  assign my = wy[51] ? 51'(-wy) : 51'(wy);

  always_ff @(posedge clk) begin
    if (advance) begin
      r0    <= y0 * $signed({1'b0, fy0_5});
      r1    <= y1 * $signed({1'b0, fy1_5});
      ahx   <= mx * cfg.inv_resolution[31:16];
      alx   <= mx * cfg.inv_resolution[15:0];
      ahy   <= my * cfg.inv_resolution[31:16];
      aly   <= my * cfg.inv_resolution[15:0];
      negx6 <= wx[51];
      negy6 <= wy[51];
      i6    <= i5;
    end
  end

  // Stage 7: floor the distance, scale the gradients toward zero and saturate.
  logic [68:0] rsum;
  logic [82:0] fullx, fully;
  logic [50:0] rrx, rry;
  logic [31:0] dist7, gx7, gy7;

  function automatic logic [31:0] sat_grad(input logic neg, input logic [50:0] r);
    logic [31:0] res;
    if (neg) begin
      res = (r > 51'h8000_0000) ? 32'h8000_0000 : (~r[31:0] + 32'd1);
    end else begin
      res = (r > 51'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end
    return res;
  endfunction

  assign rsum  = r0 + r1;
  assign fullx = {ahx, 16'd0} + 83'(alx);
  assign fully = {ahy, 16'd0} + 83'(aly);
  assign rrx   = fullx[82:32];
  assign rry   = fully[82:32];

  always_ff @(posedge clk) begin
    if (advance) begin
      dist7 <= rsum[63:32];
      gx7   <= sat_grad(negx6, rrx);
      gy7   <= sat_grad(negy6, rry);
      i7    <= i6;
    end
  end

  // Stage 8: clamp and error handling into the output register.
  logic signed [31:0] ds, lo, hi;
  logic               below, above;

  assign ds    = dist7;
  assign lo    = cfg.min_distance;
  assign hi    = cfg.max_distance;
  assign below = ds < lo;
  assign above = ds > hi;

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!i7.is_query || (i7.status != ST_OK)) begin
        status   <= i7.is_query ? i7.status : ST_OK;
        clamped  <= 1'b0;
        distance <= 32'd0;
        grad_x   <= 32'd0;
        grad_y   <= 32'd0;
      end else begin
        status   <= ST_OK;
        clamped  <= below || above;
        distance <= below ? lo : (above ? hi : ds);
        grad_x   <= (below || above) ? 32'd0 : gx7;
        grad_y   <= (below || above) ? 32'd0 : gy7;
      end
    end
  end

endmodule

@@ rtl/core/distance_field_bilinear_query_core.sv @@
// Throughput: one transaction per cycle while no output stall holds the pipeline;
// the four-bank grid gives all neighbors at once.
// The output register stalls the whole pipeline only when a result waits and is not taken.
// Reset clears the valid bits and the configuration registers to their defaults.
// The distance grid is not cleared; every cell must be written before it is queried.
module distance_field_bilinear_query_core import dfbq_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [111:0]  s_tdata,  // cell_x, cell_y, cell_distance, pos_x, pos_y
  input  logic          s_tuser,  // cmd
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [95:0]   m_tdata,  // distance, grad_x, grad_y
  output logic [2:0]    m_tuser,  // status, clamped
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  cfg_t             cfg;
  logic [8:1]       vld;
  logic             advance;
  loc_info_t        info2, info3;
  logic [XB-1:0]    ix, wr_x;
  logic [YB-1:0]    iy, wr_y;
  logic [31:0]      wr_data;
  logic [3:0][31:0] rd_data;
  status_t          status;
  logic             clamped;
  logic [31:0]      distance, grad_x, grad_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width     <= '0;
      cfg.grid_height    <= '0;
      cfg.corner_x       <= '0;
      cfg.corner_y       <= '0;
      cfg.inv_resolution <= 32'h0001_0000;
      cfg.min_distance   <= 32'hFFFF_0000;
      cfg.max_distance   <= 32'h0001_0000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:     cfg.grid_width     <= cfg_data[DIM_W-1:0];
        REG_GRID_HEIGHT:    cfg.grid_height    <= cfg_data[DIM_W-1:0];
        REG_CORNER_X:       cfg.corner_x       <= cfg_data;
        REG_CORNER_Y:       cfg.corner_y       <= cfg_data;
        REG_INV_RESOLUTION: cfg.inv_resolution <= cfg_data;
        REG_MIN_DISTANCE:   cfg.min_distance   <= cfg_data;
        REG_MAX_DISTANCE:   cfg.max_distance   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !vld[8] || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[7:1], s_tvalid};
    end
  end

  dfbq_locate u_locate (
    .clk           (clk),
    .advance       (advance),
    .cfg           (cfg),
    .in_query      (s_tuser),
    .cell_x        (s_tdata[7:0]),
    .cell_y        (s_tdata[15:8]),
    .cell_distance (s_tdata[47:16]),
    .pos_x         (s_tdata[79:48]),
    .pos_y         (s_tdata[111:80]),
    .info          (info2),
    .ix            (ix),
    .iy            (iy),
    .wr_x          (wr_x),
    .wr_y          (wr_y),
    .wr_data       (wr_data)
  );

  // Writes land at the same stage as reads, so grid accesses keep transaction order.
  dfbq_grid_mem u_grid (
    .clk     (clk),
    .advance (advance),
    .wr_en   (vld[2] && !info2.is_query),
    .wr_x    (wr_x),
    .wr_y    (wr_y),
    .wr_data (wr_data),
    .ix      (ix),
    .iy      (iy),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      info3 <= info2;
    end
  end

  dfbq_interp u_interp (
    .clk      (clk),
    .advance  (advance),
    .cfg      (cfg),
    .info     (info3),
    .rd_data  (rd_data),
    .status   (status),
    .clamped  (clamped),
    .distance (distance),
    .grad_x   (grad_x),
    .grad_y   (grad_y)
  );

  assign m_tvalid = vld[8];
  assign m_tdata  = {grad_y, grad_x, distance};
  assign m_tuser  = {clamped, status};

`ifndef SYNTHESIS
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status != ST_OK)) |-> (!clamped && (m_tdata == 96'd0)))
    else $error("error result carries nonzero payload");

  a_clamp_grad: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && clamped) |-> ((grad_x == 32'd0) && (grad_y == 32'd0)))
    else $error("clamped result has nonzero gradient");

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && clamped) |-> ((distance == cfg.min_distance) ||
                               (distance == cfg.max_distance)))
    else $error("clamped distance is not a configured limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[8] && !m_tready) |=> (vld[8] && $stable(vld)))
    else $error("pipeline moved during a stall");
`endif

endmodule
